/* hw/rtl/servo_endpoint_and_speed_calibrator_macros.svh */
// ----------------------------------------------------------------------------
// Servo endpoint and speed calibrator assertion macros
// Shared property forms for the calibrator checks.
// ----------------------------------------------------------------------------
`ifndef SERVO_ENDPOINT_AND_SPEED_CALIBRATOR_MACROS_SVH
`define SERVO_ENDPOINT_AND_SPEED_CALIBRATOR_MACROS_SVH

// same-cycle implication
`define SEC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sec assertion failed");

// next-cycle implication
`define SEC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sec assertion failed");

`endif

/* hw/rtl/sec_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sec_pkg
// Types, codes and constants of the servo endpoint and speed calibrator.
// ----------------------------------------------------------------------------
package sec_pkg;

    localparam int SEC_ADC_BITS     = 12;
    localparam int SEC_SPEED_SWEEPS = 5;
    localparam int SEC_DIV_W        = 32;
    localparam int SEC_IN_W         = 80;
    localparam int SEC_OUT_W        = 112;
    localparam int SEC_CFG_W        = 24;
    localparam int SEC_CFG_IDX_W    = 3;

    localparam logic [2:0] BEEP_NONE  = 3'd0;
    localparam logic [2:0] BEEP_MIN   = 3'd1;
    localparam logic [2:0] BEEP_MID   = 3'd2;
    localparam logic [2:0] BEEP_MAX   = 3'd3;
    localparam logic [2:0] BEEP_READY = 3'd4;
    localparam logic [2:0] BEEP_FAIL  = 3'd5;

    localparam logic [2:0] CFG_DIR      = 3'd0;
    localparam logic [2:0] CFG_PERIOD   = 3'd1;
    localparam logic [2:0] CFG_DEADBAND = 3'd2;
    localparam logic [2:0] CFG_DEFLECT  = 3'd3;
    localparam logic [2:0] CFG_LIM_MIN  = 3'd4;
    localparam logic [2:0] CFG_LIM_MID  = 3'd5;
    localparam logic [2:0] CFG_LIM_MAX  = 3'd6;

    typedef enum logic [1:0] {MODE_IDLE, MODE_SETUP, MODE_CAL} mode_t;
    typedef enum logic [1:0] {CAL_IDLE, CAL_MMM, CAL_SPEED} cal_phase_t;
    typedef enum logic [1:0] {SUB_MIN, SUB_MID, SUB_MAX} sub_phase_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_GEST, OP_TRANS, OP_WORK, OP_DIV_AVG, OP_DIV_T,
        OP_DIV_SPD, OP_STORE_AVG, OP_STORE_SPD, OP_OUT
    } dp_op_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_GEST, ST_TRANS, ST_WORK, ST_BRANCH, ST_AVG_WAIT, ST_T_WAIT,
        ST_SPD_WAIT
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic need_avg;
        logic need_spd;
        logic div_done;
    } dp_stat_t;

endpackage

/* hw/rtl/sec_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sec_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sec_div
    import sec_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SEC_DIV_W-1:0] dividend,
    input  logic [SEC_DIV_W-1:0] divisor,
    output logic                 done,
    output logic [SEC_DIV_W-1:0] quotient
);

    localparam int CW = $clog2(SEC_DIV_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [SEC_DIV_W-1:0] rem_reg, rem_next;
    logic [SEC_DIV_W-1:0] quo_reg, quo_next;
    logic [SEC_DIV_W-1:0] dvs_reg, dvs_next;
    logic [SEC_DIV_W:0]   rem_sh;
    logic [SEC_DIV_W:0]   diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg, quo_reg[SEC_DIV_W-1]};
        diff      = rem_sh - {1'b0, dvs_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(SEC_DIV_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[SEC_DIV_W])
            begin
                rem_next = diff[SEC_DIV_W-1:0];
                quo_next = {quo_reg[SEC_DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[SEC_DIV_W-1:0];
                quo_next = {quo_reg[SEC_DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hw/rtl/sec_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sec_dp
// Calibrator datapath: gesture decode, jog, calibration state and results.
// ----------------------------------------------------------------------------
module sec_dp
    import sec_pkg::*;
#(
    parameter int ADC_BITS     = SEC_ADC_BITS,
    parameter int SPEED_SWEEPS = SEC_SPEED_SWEEPS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat,
    input  logic [SEC_IN_W-1:0]      in_word,
    output logic [SEC_OUT_W-1:0]     out_word,
    input  logic                     cfg_we,
    input  logic [SEC_CFG_IDX_W-1:0] cfg_index,
    input  logic [SEC_CFG_W-1:0]     cfg_wdata
);

    localparam int CMPW = (ADC_BITS > 12 ? ADC_BITS : 12) + 2;
    localparam logic [31:0] ADC_MAX = 32'((64'd1 << ADC_BITS) - 64'd1);
    localparam logic signed [37:0] POS_LO = 38'sd900 <<< 24;
    localparam logic signed [37:0] POS_HI = 38'sd2100 <<< 24;

    logic [1:0]           dir_reg, dir_next;
    logic [23:0]          lp_reg, lp_next;
    logic [8:0]           db_reg, db_next;
    logic [9:0]           dd_reg, dd_next;
    logic [11:0]          lim_reg [3];
    logic [11:0]          lim_next [3];
    logic [ADC_BITS-1:0]  cal_reg [3];
    logic [ADC_BITS-1:0]  cal_next [3];
    mode_t                mode_reg, mode_next;
    cal_phase_t           cph_reg, cph_next;
    sub_phase_t           sub_reg, sub_next;
    sub_phase_t           at_reg, at_next;
    logic                 pdone_reg, pdone_next;
    logic                 ws_reg, ws_next;
    logic                 incal_reg, incal_next;
    logic                 navg_reg, navg_next;
    logic                 nspd_reg, nspd_next;
    logic                 tz_reg, tz_next;
    logic [35:0]          pos_reg, pos_next;
    logic [31:0]          start_reg, start_next;
    logic [31:0]          sum_reg, sum_next;
    logic [15:0]          cnt_reg, cnt_next;
    logic [15:0]          spd_reg, spd_next;
    logic [2:0]           beep_reg, beep_next;
    logic                 save_reg, save_next;
    logic [31:0]          now_reg, now_next;
    logic signed [9:0]    roll_reg, roll_next;
    logic signed [9:0]    pitch_reg, pitch_next;
    logic signed [9:0]    yaw_reg, yaw_next;
    logic [11:0]          adc_reg, adc_next;
    logic [SEC_OUT_W-1:0] out_reg, out_next;

    logic                 div_start;
    logic [31:0]          div_a;
    logic [31:0]          div_b;
    logic                 div_done;
    logic [31:0]          div_q;

    logic signed [34:0]   step;
    logic signed [37:0]   psum;
    logic [35:0]          pclamp;
    logic [31:0]          el;
    logic [31:0]          avg;
    logic [ADC_BITS-1:0]  adiff;
    logic [15:0]          cnt_inc;
    logic [CMPW-1:0]      adc_x;
    logic                 near_min;
    logic                 near_max;
    logic                 c_roll, c_pitch, c_yaw;

    function automatic logic centered(input logic signed [9:0] c, input logic [8:0] db);
        logic [10:0] a;
        a = c[9] ? ({1'b0, ~c} + 11'd1) : {1'b0, c};
        return a <= {2'b0, db};
    endfunction

    sec_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign c_roll  = centered(roll_reg, db_reg);
    assign c_pitch = centered(pitch_reg, db_reg);
    assign c_yaw   = centered(yaw_reg, db_reg);
    assign step    = yaw_reg * $signed({1'b0, lp_reg});
    assign psum    = dir_reg[1] ? ($signed({2'b0, pos_reg}) + 38'(step))
                                : ($signed({2'b0, pos_reg}) - 38'(step));
    assign pclamp  = (psum < POS_LO) ? 36'(POS_LO) :
                     (psum > POS_HI) ? 36'(POS_HI) : psum[35:0];
    assign el       = now_reg - start_reg;
    assign cnt_inc  = cnt_reg + 16'd1;
    assign adiff    = (cal_reg[0] >= cal_reg[1]) ? (cal_reg[0] - cal_reg[1])
                                                 : (cal_reg[1] - cal_reg[0]);
    assign adc_x    = CMPW'(adc_reg);
    assign near_min = adc_x < (CMPW'(cal_reg[0]) + CMPW'(10));
    assign near_max = (adc_x + CMPW'(10)) > CMPW'(cal_reg[2]);
    assign avg      = (cnt_reg == 16'd0) ? 32'd0 :
                      (div_q > ADC_MAX) ? ADC_MAX : div_q;

    always_comb
    begin
        dir_next   = dir_reg;
        lp_next    = lp_reg;
        db_next    = db_reg;
        dd_next    = dd_reg;
        lim_next   = lim_reg;
        cal_next   = cal_reg;
        mode_next  = mode_reg;
        cph_next   = cph_reg;
        sub_next   = sub_reg;
        at_next    = at_reg;
        pdone_next = pdone_reg;
        ws_next    = ws_reg;
        incal_next = incal_reg;
        navg_next  = navg_reg;
        nspd_next  = nspd_reg;
        tz_next    = tz_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        spd_next   = spd_reg;
        beep_next  = beep_reg;
        save_next  = save_reg;
        now_next   = now_reg;
        roll_next  = roll_reg;
        pitch_next = pitch_reg;
        yaw_next   = yaw_reg;
        adc_next   = adc_reg;
        out_next   = out_reg;
        div_start  = 1'b0;
        div_a      = sum_reg;
        div_b      = {16'd0, cnt_reg};

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIR:      dir_next    = cfg_wdata[1:0];
                CFG_PERIOD:   lp_next     = cfg_wdata[23:0];
                CFG_DEADBAND: db_next     = cfg_wdata[8:0];
                CFG_DEFLECT:  dd_next     = cfg_wdata[9:0];
                CFG_LIM_MIN:  lim_next[0] = cfg_wdata[11:0];
                CFG_LIM_MID:  lim_next[1] = cfg_wdata[11:0];
                CFG_LIM_MAX:  lim_next[2] = cfg_wdata[11:0];
                default:      ;
            endcase
        end

        case (cmd.op)
            OP_LOAD:
            begin
                now_next   = in_word[31:0];
                roll_next  = in_word[41:32];
                pitch_next = in_word[51:42];
                yaw_next   = in_word[61:52];
                adc_next   = in_word[73:62];
                beep_next  = BEEP_NONE;
                save_next  = 1'b0;
            end
            OP_GEST:
            begin
                if (c_pitch && roll_reg < -10'sd100)
                begin
                    pos_next = {lim_reg[0], 24'd0}; at_next = SUB_MIN;
                    beep_next = BEEP_MIN; mode_next = MODE_SETUP;
                end
                else if (c_roll && pitch_reg > 10'sd100)
                begin
                    pos_next = {lim_reg[1], 24'd0}; at_next = SUB_MID;
                    beep_next = BEEP_MID; mode_next = MODE_SETUP;
                end
                else if (c_pitch && roll_reg > 10'sd100)
                begin
                    pos_next = {lim_reg[2], 24'd0}; at_next = SUB_MAX;
                    beep_next = BEEP_MAX; mode_next = MODE_SETUP;
                end
                else if (c_roll && pitch_reg < -10'sd100)
                begin
                    mode_next = MODE_CAL; cph_next = CAL_IDLE;
                end
            end
            OP_TRANS:
            begin
                incal_next = (mode_reg == MODE_CAL);
                if (mode_reg == MODE_SETUP && !c_yaw)
                begin
                    pos_next = pclamp;
                    case (at_reg)
                        SUB_MIN: lim_next[0] = pclamp[35:24];
                        SUB_MID: lim_next[1] = pclamp[35:24];
                        SUB_MAX: lim_next[2] = pclamp[35:24];
                        default: ;
                    endcase
                end
                else if (mode_reg == MODE_CAL && (pdone_reg || cph_reg == CAL_IDLE))
                begin
                    case (cph_reg)
                        CAL_IDLE:
                        begin
                            cph_next = CAL_MMM; sub_next = SUB_MIN;
                            pos_next = {lim_reg[0], 24'd0};
                        end
                        CAL_SPEED:
                        begin
                            mode_next = MODE_IDLE; sub_next = SUB_MIN;
                            beep_next = BEEP_READY; save_next = 1'b1;
                        end
                        CAL_MMM:
                        begin
                            case (sub_reg)
                                SUB_MIN:
                                begin
                                    sub_next = SUB_MID; pos_next = {lim_reg[1], 24'd0};
                                end
                                SUB_MID:
                                begin
                                    if (32'(adiff) < 32'd100)
                                    begin
                                        mode_next = MODE_IDLE; sub_next = SUB_MIN;
                                        beep_next = BEEP_FAIL; save_next = 1'b1;
                                    end
                                    else
                                    begin
                                        sub_next = SUB_MAX;
                                        pos_next = {lim_reg[2], 24'd0};
                                    end
                                end
                                SUB_MAX:
                                begin
                                    cph_next = CAL_SPEED; sub_next = SUB_MIN;
                                    pos_next = {lim_reg[0], 24'd0}; ws_next = 1'b1;
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                    start_next = now_reg;
                    sum_next   = '0;
                    cnt_next   = '0;
                    pdone_next = 1'b0;
                end
            end
            OP_WORK:
            begin
                navg_next = 1'b0;
                nspd_next = 1'b0;
                if (incal_reg && cph_reg == CAL_MMM)
                begin
                    if (el >= 32'd600)
                    begin
                        navg_next  = 1'b1;
                        pdone_next = 1'b1;
                    end
                    else if (el >= 32'd500)
                    begin
                        sum_next = sum_reg + 32'(adc_reg);
                        cnt_next = cnt_inc;
                    end
                end
                else if (incal_reg && cph_reg == CAL_SPEED)
                begin
                    if ((sub_reg == SUB_MIN && near_min) ||
                        (sub_reg == SUB_MAX && near_max))
                    begin
                        if (!ws_reg)
                        begin
                            sum_next   = sum_reg + el;
                            cnt_next   = cnt_inc;
                            start_next = now_reg;
                            ws_next    = 1'b1;
                            if (sub_reg == SUB_MIN && cnt_inc > 16'(SPEED_SWEEPS))
                            begin
                                nspd_next = 1'b1;
                                pos_next  = {lim_reg[1], 24'd0};
                            end
                        end
                        else if (el >= 32'd200)
                        begin
                            start_next = now_reg;
                            ws_next    = 1'b0;
                            if (sub_reg == SUB_MIN)
                            begin
                                sub_next = SUB_MAX; pos_next = {lim_reg[2], 24'd0};
                            end
                            else
                            begin
                                sub_next = SUB_MIN; pos_next = {lim_reg[0], 24'd0};
                            end
                        end
                    end
                end
            end
            OP_DIV_AVG, OP_DIV_T:
            begin
                div_start = 1'b1;
            end
            OP_DIV_SPD:
            begin
                div_start = 1'b1;
                div_a     = 32'(18'(dd_reg) * 18'd200);
                div_b     = div_q;
                tz_next   = (div_q == 32'd0);
            end
            OP_STORE_AVG:
            begin
                case (sub_reg)
                    SUB_MIN: cal_next[0] = avg[ADC_BITS-1:0];
                    SUB_MID: cal_next[1] = avg[ADC_BITS-1:0];
                    SUB_MAX: cal_next[2] = avg[ADC_BITS-1:0];
                    default: ;
                endcase
            end
            OP_STORE_SPD:
            begin
                spd_next   = (tz_reg || div_q > 32'd65535) ? 16'hFFFF : div_q[15:0];
                pdone_next = 1'b1;
            end
            OP_OUT:
            begin
                out_next = {6'd0, mode_reg, save_reg, beep_reg, spd_reg,
                            12'(cal_reg[2]), 12'(cal_reg[1]), 12'(cal_reg[0]),
                            lim_reg[2], lim_reg[1], lim_reg[0], pos_reg[35:24]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg   <= 2'b01;
            lp_reg    <= 24'd2097;
            db_reg    <= 9'd20;
            dd_reg    <= 10'd400;
            lim_reg   <= '{12'd1000, 12'd1500, 12'd2000};
            cal_reg   <= '{'0, '0, '0};
            mode_reg  <= MODE_IDLE;
            cph_reg   <= CAL_IDLE;
            sub_reg   <= SUB_MIN;
            at_reg    <= SUB_MIN;
            pdone_reg <= 1'b0;
            ws_reg    <= 1'b0;
            incal_reg <= 1'b0;
            navg_reg  <= 1'b0;
            nspd_reg  <= 1'b0;
            tz_reg    <= 1'b0;
            pos_reg   <= '0;
            start_reg <= '0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            spd_reg   <= '0;
            beep_reg  <= BEEP_NONE;
            save_reg  <= 1'b0;
        end
        else
        begin
            dir_reg   <= dir_next;
            lp_reg    <= lp_next;
            db_reg    <= db_next;
            dd_reg    <= dd_next;
            lim_reg   <= lim_next;
            cal_reg   <= cal_next;
            mode_reg  <= mode_next;
            cph_reg   <= cph_next;
            sub_reg   <= sub_next;
            at_reg    <= at_next;
            pdone_reg <= pdone_next;
            ws_reg    <= ws_next;
            incal_reg <= incal_next;
            navg_reg  <= navg_next;
            nspd_reg  <= nspd_next;
            tz_reg    <= tz_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            spd_reg   <= spd_next;
            beep_reg  <= beep_next;
            save_reg  <= save_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg   <= now_next;
        roll_reg  <= roll_next;
        pitch_reg <= pitch_next;
        yaw_reg   <= yaw_next;
        adc_reg   <= adc_next;
        out_reg   <= out_next;
    end

    assign stat.need_avg = navg_reg;
    assign stat.need_spd = nspd_reg;
    assign stat.div_done = div_done;
    assign out_word      = out_reg;

endmodule

/* hw/rtl/sec_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sec_ctrl
// Per-word sequencer: handshakes and datapath step commands.
// ----------------------------------------------------------------------------
module sec_ctrl
    import sec_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    ctrl_state_t state_reg, state_next;
    logic        ovalid_reg, ovalid_next;
    logic        out_free;

    assign out_free = !ovalid_reg || m_tready;

    always_comb
    begin
        state_next  = state_reg;
        cmd.op      = OP_NONE;
        s_tready    = 1'b0;
        ovalid_next = ovalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_GEST;
                end
            end
            ST_GEST:
            begin
                cmd.op     = OP_GEST;
                state_next = ST_TRANS;
            end
            ST_TRANS:
            begin
                cmd.op     = OP_TRANS;
                state_next = ST_WORK;
            end
            ST_WORK:
            begin
                cmd.op     = OP_WORK;
                state_next = ST_BRANCH;
            end
            ST_BRANCH:
            begin
                if (stat.need_avg)
                begin
                    cmd.op     = OP_DIV_AVG;
                    state_next = ST_AVG_WAIT;
                end
                else if (stat.need_spd)
                begin
                    cmd.op     = OP_DIV_T;
                    state_next = ST_T_WAIT;
                end
                else if (out_free)
                begin
                    cmd.op      = OP_OUT;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_AVG_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_STORE_AVG;
                    state_next = ST_SPD_WAIT;
                end
            end
            ST_T_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_DIV_SPD;
                    state_next = ST_AVG_WAIT;
                end
            end
            ST_SPD_WAIT:
            begin
                // result ready, waiting on the output register
                if (out_free)
                begin
                    cmd.op      = OP_OUT;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // speed quotient lands through the same wait state as the average
        if (state_reg == ST_AVG_WAIT && stat.div_done && stat.need_spd)
        begin
            cmd.op = OP_STORE_SPD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign m_tvalid = ovalid_reg;

endmodule

/* hw/rtl/servo_endpoint_and_speed_calibrator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_endpoint_and_speed_calibrator
// Stick-gesture servo endpoint setup and feedback/speed calibration.
// ----------------------------------------------------------------------------
// One control tick word in, one result word out. A word runs through five
// sequencer steps (load, gesture, jog or phase change, phase work, output).
// A tick that closes a 500-600 ms averaging window adds one pass of the
// 32-step restoring divider plus a store step; the tick that ends the speed
// sweeps adds two passes. The divider yields one quotient bit per cycle. A
// new word is taken once the previous result sits in the output register;
// a stalled output holds the sequencer at its output step.
module servo_endpoint_and_speed_calibrator
    import sec_pkg::*;
#(
    parameter int ADC_BITS     = SEC_ADC_BITS,
    parameter int SPEED_SWEEPS = SEC_SPEED_SWEEPS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // now_ms, roll_cmd, pitch_cmd, yaw_cmd, feedback_adc
    input  logic [SEC_IN_W-1:0]      s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // servo_out, limit_min, limit_mid, limit_max, adc_at_min, adc_at_mid,
    // adc_at_max, servo_speed, beep_event, save_request, mode
    output logic [SEC_OUT_W-1:0]     m_tdata,
    input  logic                     cfg_we,
    input  logic [SEC_CFG_IDX_W-1:0] cfg_index,
    input  logic [SEC_CFG_W-1:0]     cfg_wdata
);

    `include "servo_endpoint_and_speed_calibrator_macros.svh"

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    sec_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (dp_cmd),
        .stat     (dp_stat)
    );

    sec_dp #(
        .ADC_BITS     (ADC_BITS),
        .SPEED_SWEEPS (SPEED_SWEEPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .in_word   (s_tdata),
        .out_word  (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    `SEC_ASSERT_NXT(a_one_word, s_tvalid && s_tready, !s_tready)
    `SEC_ASSERT_IMP(a_idle_quiet, s_tready && !s_tvalid, dp_cmd.op == OP_NONE)
    `SEC_ASSERT_IMP(a_save_beep, m_tvalid && m_tdata[103],
        m_tdata[102:100] == BEEP_READY || m_tdata[102:100] == BEEP_FAIL)

endmodule

/* verif/servo_cal_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_cal_checker
// Watches the tick, result and register ports of the servo calibrator, keeps
// its own copy of the calibrator state, predicts each result word and
// compares it field by field with the word the block returns.
// ----------------------------------------------------------------------------
module servo_cal_checker
    import sec_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [SEC_IN_W-1:0]      s_tdata,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [SEC_OUT_W-1:0]     m_tdata,
    input  logic                     cfg_we,
    input  logic [SEC_CFG_IDX_W-1:0] cfg_index,
    input  logic [SEC_CFG_W-1:0]     cfg_wdata,
    output int                       errors,
    output int                       pending,
    output int                       results,
    output int                       saves
);

    localparam int NF = 11;
    localparam int FLSB [NF] = '{0, 12, 24, 36, 48, 60, 72, 84, 100, 103, 104};
    localparam int FW   [NF] = '{12, 12, 12, 12, 12, 12, 12, 16, 3, 1, 2};
    localparam string FNAME [NF] = '{"servo_out", "limit_min", "limit_mid", "limit_max",
        "adc_at_min", "adc_at_mid", "adc_at_max", "servo_speed", "beep_event",
        "save_request", "mode"};
    localparam longint POS_LO = longint'(900) << 24;
    localparam longint POS_HI = longint'(2100) << 24;

    logic [1:0]  dir;
    logic [23:0] period;
    logic [8:0]  deadband;
    logic [9:0]  deflect;
    mode_t       md;
    cal_phase_t  cph;
    sub_phase_t  sph;
    logic        done, wstop;
    logic [1:0]  tgt;
    logic [35:0] pos;
    logic [11:0] lims [3];
    logic [11:0] adcc [3];
    logic [31:0] pstart, ssum;
    logic [15:0] scnt, speed;

    logic [SEC_OUT_W-1:0] expected_words [$];
    int reported;

    function automatic bit centered(int c);
        return (c < 0 ? -c : c) <= int'(deadband);
    endfunction

    function automatic logic [35:0] at_us(logic [11:0] us);
        return {us, 24'd0};
    endfunction

    function automatic logic [SEC_OUT_W-1:0] calibrate_tick(logic [SEC_IN_W-1:0] d);
        logic [31:0] now, el, avg, t, q;
        int roll, pitch, yaw, adc;
        logic [2:0] beep;
        logic save;
        longint step, p;
        now = d[31:0];
        roll = $signed(d[41:32]);
        pitch = $signed(d[51:42]);
        yaw = $signed(d[61:52]);
        adc = int'(d[73:62]);
        beep = BEEP_NONE;
        save = 1'b0;

        if (centered(pitch) && roll < -100) begin
            pos = at_us(lims[0]); tgt = 2'd0; beep = BEEP_MIN; md = MODE_SETUP;
        end else if (centered(roll) && pitch > 100) begin
            pos = at_us(lims[1]); tgt = 2'd1; beep = BEEP_MID; md = MODE_SETUP;
        end else if (centered(pitch) && roll > 100) begin
            pos = at_us(lims[2]); tgt = 2'd2; beep = BEEP_MAX; md = MODE_SETUP;
        end else if (centered(roll) && pitch < -100) begin
            md = MODE_CAL; cph = CAL_IDLE;
        end

        if (md == MODE_SETUP) begin
            if (!centered(yaw)) begin
                step = longint'(yaw) * longint'(period);
                p = longint'(pos);
                p = dir[1] ? p + step : p - step;
                if (p < POS_LO) p = POS_LO;
                if (p > POS_HI) p = POS_HI;
                pos = p[35:0];
                lims[tgt] = p[35:24];
            end
        end else if (md == MODE_CAL) begin
            if (done || cph == CAL_IDLE) begin
                if (cph == CAL_IDLE) begin
                    cph = CAL_MMM; sph = SUB_MIN; pos = at_us(lims[0]);
                end else if (cph == CAL_SPEED) begin
                    md = MODE_IDLE; sph = SUB_MIN; beep = BEEP_READY; save = 1'b1;
                end else if (sph == SUB_MIN) begin
                    sph = SUB_MID; pos = at_us(lims[1]);
                end else if (sph == SUB_MID) begin
                    if ((int'(adcc[0]) - int'(adcc[1]) < 100) &&
                        (int'(adcc[1]) - int'(adcc[0]) < 100)) begin
                        md = MODE_IDLE; sph = SUB_MIN; beep = BEEP_FAIL; save = 1'b1;
                    end else begin
                        sph = SUB_MAX; pos = at_us(lims[2]);
                    end
                end else if (sph == SUB_MAX) begin
                    cph = CAL_SPEED; sph = SUB_MIN; pos = at_us(lims[0]); wstop = 1'b1;
                end
                pstart = now; ssum = '0; scnt = '0; done = 1'b0;
            end
            if (cph == CAL_MMM) begin
                el = now - pstart;
                if (el >= 600) begin
                    avg = (scnt != 0) ? ssum / 32'(scnt) : 32'd0;
                    if (avg > 4095) avg = 4095;
                    adcc[sph] = avg[11:0];
                    done = 1'b1;
                end else if (el >= 500) begin
                    ssum = ssum + 32'(adc); scnt = scnt + 16'd1;
                end
            end else if (cph == CAL_SPEED) begin
                if (sph == SUB_MIN) begin
                    if (adc < int'(adcc[0]) + 10) begin
                        if (!wstop) begin
                            ssum = ssum + (now - pstart);
                            scnt = scnt + 16'd1;
                            if (scnt > SEC_SPEED_SWEEPS) begin
                                t = ssum / 32'(scnt);
                                if (t == 0) speed = 16'hFFFF;
                                else begin
                                    q = (32'd200 * 32'(deflect)) / t;
                                    speed = (q > 65535) ? 16'hFFFF : q[15:0];
                                end
                                done = 1'b1;
                                pos = at_us(lims[1]);
                            end
                            pstart = now; wstop = 1'b1;
                        end else if (now - pstart >= 200) begin
                            pstart = now; sph = SUB_MAX; wstop = 1'b0; pos = at_us(lims[2]);
                        end
                    end
                end else if (sph == SUB_MAX) begin
                    if (adc > int'(adcc[2]) - 10) begin
                        if (!wstop) begin
                            ssum = ssum + (now - pstart);
                            scnt = scnt + 16'd1;
                            pstart = now; wstop = 1'b1;
                        end else if (now - pstart >= 200) begin
                            pstart = now; sph = SUB_MIN; wstop = 1'b0; pos = at_us(lims[0]);
                        end
                    end
                end
            end
        end
        return {6'd0, md, save, beep, speed, adcc[2], adcc[1], adcc[0],
                lims[2], lims[1], lims[0], pos[35:24]};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [SEC_OUT_W-1:0] want;
        logic [15:0] a, b;
        bit bad;
        if (!rst_n)
        begin
            dir = 2'd1; period = 24'd2097; deadband = 9'd20; deflect = 10'd400;
            md = MODE_IDLE; cph = CAL_IDLE; sph = SUB_MIN; done = 0; wstop = 0;
            tgt = 2'd0; pos = '0;
            lims[0] = 12'd1000; lims[1] = 12'd1500; lims[2] = 12'd2000;
            adcc[0] = '0; adcc[1] = '0; adcc[2] = '0;
            pstart = '0; ssum = '0; scnt = '0; speed = '0;
            expected_words.delete();
            errors <= 0; results <= 0; saves <= 0; pending <= 0;
            reported = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DIR:      dir = cfg_wdata[1:0];
                    CFG_PERIOD:   period = cfg_wdata[23:0];
                    CFG_DEADBAND: deadband = cfg_wdata[8:0];
                    CFG_DEFLECT:  deflect = cfg_wdata[9:0];
                    CFG_LIM_MIN:  lims[0] = cfg_wdata[11:0];
                    CFG_LIM_MID:  lims[1] = cfg_wdata[11:0];
                    CFG_LIM_MAX:  lims[2] = cfg_wdata[11:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_words.push_back(calibrate_tick(s_tdata));
            if (m_tvalid && m_tready)
            begin
                results <= results + 1;
                if (m_tdata[103]) saves <= saves + 1;
                if (expected_words.size() == 0)
                begin
                    errors <= errors + 1;
                    if (reported < 10)
                        $display("[%0t] result word with nothing expected: %h", $time, m_tdata);
                    reported++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    bad = 0;
                    for (int f = 0; f < NF; f++)
                    begin
                        a = 16'((want >> FLSB[f]) & ((1 << FW[f]) - 1));
                        b = 16'((m_tdata >> FLSB[f]) & ((1 << FW[f]) - 1));
                        if (a != b)
                        begin
                            bad = 1;
                            if (reported < 10)
                                $display("[%0t] %s mismatch: expected %0d got %0d",
                                         $time, FNAME[f], a, b);
                        end
                    end
                    if (bad)
                    begin
                        errors <= errors + 1;
                        reported++;
                    end
                end
            end
            pending <= expected_words.size();
        end
    end

endmodule

/* verif/tb_servo_endpoint_and_speed_calibrator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_servo_endpoint_and_speed_calibrator
// Drives control ticks into the servo calibrator: directed extremes and
// gestures, then random phases of endpoint jogging, full calibration runs fed
// by a crude servo feedback model, and noise, under several register settings.
// ----------------------------------------------------------------------------
module tb_servo_endpoint_and_speed_calibrator;
    import sec_pkg::*;

    localparam int WD_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [SEC_IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [SEC_OUT_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [SEC_CFG_IDX_W-1:0] cfg_index = '0;
    logic [SEC_CFG_W-1:0] cfg_wdata = '0;

    int errors, pending, results, saves;
    int sent = 0;
    int wd = 0;
    int rx_stall = 0;
    int cur_db = 20;
    bit quiet = 0;
    logic [31:0] now_t = 0;
    logic [11:0] last_srv = 0;
    logic [1:0] last_mode = 0;

    always #6 clk = ~clk;

    servo_endpoint_and_speed_calibrator uut (.*);

    servo_cal_checker chk (.*);

    always @(posedge clk)
    begin
        int n;
        n = rx_stall;
        if (m_tvalid && m_tready)
        begin
            last_srv <= m_tdata[11:0];
            last_mode <= m_tdata[105:104];
            n = quiet ? 0 : $urandom_range(0, 3);
        end
        else if (n > 0)
            n--;
        rx_stall <= n;
        m_tready <= rst_n && n == 0;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
            wd <= 0;
        else
            wd <= wd + 1;
        if (wd >= WD_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_tick(int roll, int pitch, int yaw, int adc);
        int gap;
        bit ok;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, 12'(adc), 10'(yaw), 10'(pitch), 10'(roll), now_t};
        do
        begin
            @(negedge clk);
            ok = s_tready;
            @(posedge clk);
        end
        while (!ok);
        sent++;
    endtask

    function automatic int ctr();
        return int'($urandom_range(0, 2 * cur_db)) - cur_db;
    endfunction

    function automatic int feedback();
        int v;
        v = int'(last_srv) * 3 / 2 + int'($urandom_range(0, 12));
        return v > 4095 ? 4095 : v;
    endfunction

    task automatic jog_run();
        int g, n, y;
        g = $urandom_range(0, 2);
        now_t = now_t + $urandom_range(0, 40);
        case (g)
            0: send_tick(-int'($urandom_range(101, 512)), ctr(), 0, $urandom_range(0, 4095));
            1: send_tick(ctr(), $urandom_range(101, 511), 0, $urandom_range(0, 4095));
            default: send_tick($urandom_range(101, 511), ctr(), 0, $urandom_range(0, 4095));
        endcase
        n = $urandom_range(3, 20);
        repeat (n)
        begin
            y = int'($urandom_range(0, 1023)) - 512;
            now_t = now_t + $urandom_range(0, 40);
            send_tick(ctr(), ctr(), y, $urandom_range(0, 4095));
        end
    endtask

    task automatic cal_run();
        int k;
        now_t = now_t + $urandom_range(0, 40);
        send_tick(ctr(), -int'($urandom_range(101, 512)), ctr(), feedback());
        for (k = 0; k < 160; k++)
        begin
            if (k > 4 && last_mode == MODE_IDLE) break;
            now_t = now_t + (($urandom_range(0, 15) == 0) ? 0 : $urandom_range(20, 70));
            send_tick(ctr(), ctr(), ctr(), feedback());
        end
    endtask

    task automatic noise_run();
        repeat ($urandom_range(1, 5))
        begin
            if ($urandom_range(0, 3) == 0) now_t = $urandom;
            else now_t = now_t + $urandom_range(0, 700);
            send_tick($urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 1023), $urandom_range(0, 4095));
        end
    endtask

    task automatic set_reg(logic [SEC_CFG_IDX_W-1:0] idx, int val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= SEC_CFG_W'(val);
        @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || s_tvalid) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic configure(int ph);
        int dirv, per, lmn, lmd, lmx, dfl;
        dirv = ph % 4;
        if (ph == 0)
        begin
            per = 24'hFFFFFF; cur_db = 500; dfl = 900; lmn = 2500; lmd = 2500; lmx = 2500;
        end
        else if (ph == 1)
        begin
            per = 0; cur_db = 0; dfl = 0; lmn = 500; lmd = 500; lmx = 500;
        end
        else
        begin
            per = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1 << 21)
                                              : $urandom_range(0, 24'hFFFFFF);
            cur_db = $urandom_range(0, 3) == 0 ? $urandom_range(0, 511) : $urandom_range(0, 60);
            dfl = $urandom_range(0, 1023);
            lmn = $urandom_range(500, 1300);
            lmd = $urandom_range(1300, 1700);
            lmx = $urandom_range(1700, 2500);
            if ($urandom_range(0, 4) == 0) lmd = lmn + $urandom_range(0, 40);
            if ($urandom_range(0, 6) == 0) lmx = $urandom_range(0, 4095);
        end
        set_reg(CFG_DIR, dirv);
        set_reg(CFG_PERIOD, per);
        set_reg(CFG_DEADBAND, cur_db);
        set_reg(CFG_DEFLECT, dfl);
        set_reg(CFG_LIM_MIN, lmn);
        set_reg(CFG_LIM_MID, lmd);
        set_reg(CFG_LIM_MAX, lmx);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int r, mark;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes and every gesture at the reset setting
        now_t = 0;              send_tick(0, 0, 0, 0);
        now_t = 32'hFFFFFFFF;   send_tick(-512, -512, -512, 4095);
        now_t = 5;              send_tick(511, 511, 511, 4095);
        send_tick(-512, 0, 511, 0);
        send_tick(0, 0, 511, 1234);
        send_tick(0, 0, -512, 2345);
        send_tick(0, 511, -300, 0);
        send_tick(511, 0, 300, 0);
        send_tick(-101, 20, 0, 0);
        send_tick(-100, 0, 0, 0);
        send_tick(0, -101, 0, 100);
        now_t = 600;            send_tick(0, 0, 0, 4095);
        now_t = 1100;           send_tick(0, 0, 0, 0);
        now_t = 1150;           send_tick(0, 0, 0, 4095);
        now_t = 1300;           send_tick(0, 0, 0, 4095);
        now_t = 2000;           send_tick(0, -512, 0, 3000);
        send_tick(0, -512, 0, 3000);
        send_tick(21, 101, 0, 0);
        send_tick(0, 0, 21, 0);
        send_tick(0, 0, -21, 0);

        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            configure(ph);
            quiet = (ph == 3);
            mark = sent;
            while (sent - mark < 250)
            begin
                r = $urandom_range(0, 9);
                if (r < 2) noise_run();
                else if (r < 5) jog_run();
                else cal_run();
            end
        end
        quiet = 0;
        drain();

        $display("ticks sent %0d, results checked %0d, calibrations ended with save %0d",
                 sent, results, saves);
        $display("six register settings including both extremes, jog and calibration runs");
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* servo_endpoint_and_speed_calibrator.f */
+incdir+hw/rtl
hw/rtl/sec_pkg.sv
hw/rtl/sec_div.sv
hw/rtl/sec_dp.sv
hw/rtl/sec_ctrl.sv
hw/rtl/servo_endpoint_and_speed_calibrator.sv
verif/servo_cal_checker.sv
verif/tb_servo_endpoint_and_speed_calibrator.sv
